// ===== rtl/utf8_to_codepoint_decoder_unit_assert.svh =====
// Assertion macros shared by the decoder's checker.
`ifndef UTF8_TO_CODEPOINT_DECODER_UNIT_ASSERT_SVH
`define UTF8_TO_CODEPOINT_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication under a reset guard.
`define U8D_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under a reset guard.
`define U8D_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/utf8dec_pkg.sv =====
// Shared types and codes for the UTF-8 to code point decoder.
package utf8dec_pkg;

   localparam int BYTE_W  = 8;
   localparam int CP_W    = 21;
   localparam int STAT_W  = 3;
   localparam int KIND_W  = 3;
   localparam int BITS_W  = 7;

   // Byte classes found by the front end
   localparam logic [KIND_W-1:0] KIND_ASCII = 3'd0;
   localparam logic [KIND_W-1:0] KIND_NUL   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_LEAD2 = 3'd2;
   localparam logic [KIND_W-1:0] KIND_LEAD3 = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LEAD4 = 3'd4;
   localparam logic [KIND_W-1:0] KIND_CONT  = 3'd5;
   localparam logic [KIND_W-1:0] KIND_BAD   = 3'd6;

   // Result status codes
   localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
   localparam logic [STAT_W-1:0] ST_BAD_LEAD = 3'd1;
   localparam logic [STAT_W-1:0] ST_BAD_CONT = 3'd2;
   localparam logic [STAT_W-1:0] ST_TRUNC    = 3'd3;
   localparam logic [STAT_W-1:0] ST_NUL      = 3'd4;

   // One classified byte on its way to the back end
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BITS_W-1:0] bits;   // payload bits of the byte, already masked
      logic              last;
   } dec_item_type;

endpackage

// ===== rtl/utf8dec_front.sv =====
// Front end: takes raw bytes, classifies them and registers the item.
module utf8dec_front
   import utf8dec_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [BYTE_W-1:0] in_byte,
   input  logic              in_last,
   output logic              out_valid,
   input  logic              out_ready,
   output dec_item_type      out_item
);

   logic         valid_ff, valid_in;
   dec_item_type item_ff, item_in;

   assign in_ready = !valid_ff || out_ready;

   // Byte classification and payload masking
   always_comb begin
      item_in.last = in_last;
      item_in.bits = in_byte[BITS_W-1:0];
      if (!in_byte[7]) begin
         item_in.kind = (in_byte == '0) ? KIND_NUL : KIND_ASCII;
      end else if (!in_byte[6]) begin
         item_in.kind = KIND_CONT;
         item_in.bits = {1'b0, in_byte[5:0]};
      end else if (!in_byte[5]) begin
         item_in.kind = KIND_LEAD2;
         item_in.bits = {2'b0, in_byte[4:0]};
      end else if (!in_byte[4]) begin
         item_in.kind = KIND_LEAD3;
         item_in.bits = {3'b0, in_byte[3:0]};
      end else if (!in_byte[3]) begin
         item_in.kind = KIND_LEAD4;
         item_in.bits = {4'b0, in_byte[2:0]};
      end else begin
         item_in.kind = KIND_BAD;
         item_in.bits = '0;
      end
   end

   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== rtl/utf8dec_queue.sv =====
// Small queue that decouples the front end from the back end.
module utf8dec_queue
   import utf8dec_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  dec_item_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output dec_item_type out_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   dec_item_type store [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = store[rd_ptr_ff];

   // Pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// ===== rtl/utf8dec_back.sv =====
// Back end: sequence state, code point assembly and the result register.
module utf8dec_back
   import utf8dec_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  dec_item_type      in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [CP_W-1:0]   out_code_point,
   output logic [STAT_W-1:0] out_status,
   output logic              out_end
);

   logic [CP_W-1:0]   acc_ff, acc_in;
   logic [1:0]        rem_ff, rem_in;
   logic              stopped_ff, stopped_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CP_W-1:0]   rsp_cp_ff;
   logic [STAT_W-1:0] rsp_status_ff;
   logic              rsp_end_ff;

   logic              pop;
   logic              emit;
   logic [CP_W-1:0]   emit_cp;
   logic [STAT_W-1:0] emit_status;
   logic [CP_W-1:0]   acc_shift;
   logic [1:0]        rem_dec;

   assign in_ready  = !rsp_valid_ff || out_ready;
   assign pop       = in_valid && in_ready;
   assign acc_shift = {acc_ff[CP_W-7:0], in_item.bits[5:0]};
   assign rem_dec   = rem_ff - 2'd1;

   // Decode step for one item
   always_comb begin
      acc_in      = acc_ff;
      rem_in      = rem_ff;
      stopped_in  = stopped_ff;
      emit        = 1'b0;
      emit_cp     = '0;
      emit_status = ST_OK;
      if (stopped_ff) begin
         if (in_item.last) begin
            stopped_in = 1'b0;
            acc_in     = '0;
            rem_in     = '0;
         end
      end else if (rem_ff == 2'd0) begin
         case (in_item.kind)
            KIND_ASCII: begin
               emit    = 1'b1;
               emit_cp = CP_W'(in_item.bits);
            end
            KIND_NUL: begin
               emit        = 1'b1;
               emit_status = ST_NUL;
            end
            KIND_LEAD2, KIND_LEAD3, KIND_LEAD4: begin
               acc_in = CP_W'(in_item.bits);
               rem_in = (in_item.kind == KIND_LEAD2) ? 2'd1 :
                        (in_item.kind == KIND_LEAD3) ? 2'd2 : 2'd3;
               if (in_item.last) begin
                  emit        = 1'b1;
                  emit_status = ST_TRUNC;
               end
            end
            default: begin
               emit        = 1'b1;
               emit_status = ST_BAD_LEAD;
            end
         endcase
      end else if (in_item.kind == KIND_CONT) begin
         acc_in = acc_shift;
         rem_in = rem_dec;
         if (rem_dec == 2'd0) begin
            acc_in      = '0;
            emit        = 1'b1;
            emit_cp     = acc_shift;
            emit_status = (acc_shift == '0) ? ST_NUL : ST_OK;
         end else if (in_item.last) begin
            emit        = 1'b1;
            emit_status = ST_TRUNC;
         end
      end else begin
         emit        = 1'b1;
         emit_status = ST_BAD_CONT;
      end

      // Stop handling and end-of-string clear
      if (emit && emit_status != ST_OK) begin
         emit_cp    = '0;
         acc_in     = '0;
         rem_in     = '0;
         stopped_in = !in_item.last;
      end else if (emit && in_item.last) begin
         acc_in     = '0;
         rem_in     = '0;
         stopped_in = 1'b0;
      end
   end

   assign rsp_valid_in = pop ? emit : (rsp_valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         rem_ff       <= '0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            acc_ff     <= acc_in;
            rem_ff     <= rem_in;
            stopped_ff <= stopped_in;
         end
      end
   end

   // Result payload register
   always_ff @(posedge clock) begin
      if (pop && emit) begin
         rsp_cp_ff     <= emit_cp;
         rsp_status_ff <= emit_status;
         rsp_end_ff    <= in_item.last || (emit_status != ST_OK);
      end
   end

   assign out_valid      = rsp_valid_ff;
   assign out_code_point = rsp_cp_ff;
   assign out_status     = rsp_status_ff;
   assign out_end        = rsp_end_ff;

endmodule

// ===== rtl/utf8_to_codepoint_decoder_unit.sv =====
// Top level of the UTF-8 to code point decoder.
// A byte passes the front-end register, the queue store and the back-end result register on its way to the output.
// Throughput: one byte per clock while the receiver takes results, as the back end's decode step is combinational.
// The queue between front and back holds QUEUE_DEPTH items so each side can stall alone.
// Reset clears all control and decode state at once; no clearing pass is needed.
module utf8_to_codepoint_decoder_unit
   import utf8dec_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [20:0] code_point, [23:21] zero
   output logic [2:0]  rsp_tuser,   // [2:0] status
   output logic        rsp_tlast    // end_of_string
);

   logic            fr_valid, fr_ready;
   dec_item_type    fr_item;
   logic            q_valid, q_ready;
   dec_item_type    q_item;
   logic [CP_W-1:0] code_point;

   utf8dec_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata),
      .in_last   (req_tlast),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_item  (fr_item)
   );

   utf8dec_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_item   (fr_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   utf8dec_back u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (q_valid),
      .in_ready       (q_ready),
      .in_item        (q_item),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_code_point (code_point),
      .out_status     (rsp_tuser),
      .out_end        (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, code_point};

endmodule

// ===== rtl/utf8dec_checker.sv =====
// Port-level checker for the decoder, bound to the top level.
`include "utf8_to_codepoint_decoder_unit_assert.svh"

module utf8dec_checker
   import utf8dec_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // Any failing status closes the string with a zero code point
   `U8D_ASSERT_SAME(a_err_zero_cp, clock, reset, rsp_tvalid && (rsp_tuser != ST_OK), rsp_tdata == 24'd0, "error result carries a code point")
   `U8D_ASSERT_SAME(a_err_ends, clock, reset, rsp_tvalid && (rsp_tuser != ST_OK), rsp_tlast, "error result without end of string")
   // A zero value is always reported as a terminator
   `U8D_ASSERT_SAME(a_ok_nonzero, clock, reset, rsp_tvalid && (rsp_tuser == ST_OK), rsp_tdata != 24'd0, "ok result with zero code point")
   // A stalled item holds still
   `U8D_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled item changed")
   // Nothing is offered right after reset
   `U8D_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_tvalid, "result offered after reset")

endmodule

bind utf8_to_codepoint_decoder_unit utf8dec_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== tb/utf8_decode_checker.sv =====
// Checker for the UTF-8 decoder: predicts code points from accepted bytes and compares results.
`timescale 1ns / 1ps

module utf8_decode_checker
   import utf8dec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // [20:0] code_point, [23:21] zero
   input  logic [2:0]  rsp_tuser,   // [2:0] status
   input  logic        rsp_tlast,   // end_of_string
   output int          fail_count,
   output int          outstanding
);

   typedef struct packed {
      logic [CP_W-1:0]   cp;
      logic [STAT_W-1:0] status;
      logic              eos;
   } code_point_result_type;

   localparam int REPORT_LIMIT = 10;

   // Decoder state as predicted
   logic [CP_W-1:0] acc_bits;
   logic [1:0]      conts_left;
   logic            dropping;

   code_point_result_type expected_points[$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
      acc_bits    = '0;
      conts_left  = '0;
      dropping    = 1'b0;
   end

   // Build one result and apply the stop / end-of-string rules to the state
   task automatic close_point(input logic [STAT_W-1:0] st, input logic [CP_W-1:0] cp,
                              input logic is_last, output code_point_result_type res);
      res.status = st;
      res.cp     = (st == ST_OK) ? cp : '0;
      res.eos    = is_last || (st != ST_OK);
      acc_bits   = '0;
      conts_left = '0;
      dropping   = (st != ST_OK) && !is_last;
   endtask

   // Predict the effect of one accepted byte
   task automatic decode_byte(input logic [7:0] b, input logic is_last,
                              output logic has_result, output code_point_result_type res);
      logic [CP_W-1:0] joined;
      has_result = 1'b0;
      res        = '0;
      if (dropping) begin
         // drop up to and including the byte marked last
         if (is_last) begin
            acc_bits   = '0;
            conts_left = '0;
            dropping   = 1'b0;
         end
      end else if (conts_left == 2'd0) begin
         if (!b[7]) begin
            has_result = 1'b1;
            close_point((b == 8'h00) ? ST_NUL : ST_OK, {14'd0, b[6:0]}, is_last, res);
         end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
            if (b[7:5] == 3'b110) begin
               acc_bits   = {16'd0, b[4:0]};
               conts_left = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
               acc_bits   = {17'd0, b[3:0]};
               conts_left = 2'd2;
            end else begin
               acc_bits   = {18'd0, b[2:0]};
               conts_left = 2'd3;
            end
            if (is_last) begin
               has_result = 1'b1;
               close_point(ST_TRUNC, '0, 1'b1, res);
            end
         end else begin
            // lone continuation or 11111xxx in lead position
            has_result = 1'b1;
            close_point(ST_BAD_LEAD, '0, is_last, res);
         end
      end else if (b[7:6] == 2'b10) begin
         joined     = {acc_bits[CP_W-7:0], b[5:0]};
         acc_bits   = joined;
         conts_left = conts_left - 2'd1;
         if (conts_left == 2'd0) begin
            has_result = 1'b1;
            close_point((joined == '0) ? ST_NUL : ST_OK, joined, is_last, res);
         end else if (is_last) begin
            has_result = 1'b1;
            close_point(ST_TRUNC, '0, 1'b1, res);
         end
      end else begin
         has_result = 1'b1;
         close_point(ST_BAD_CONT, '0, is_last, res);
      end
   endtask

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
         $display("%0t: decoder mismatch: %s", $realtime, msg);
   endtask

   // Track accepted bytes and results
   always @(posedge clock) begin
      logic                  produced;
      code_point_result_type res;
      code_point_result_type want;
      if (reset) begin
         acc_bits   = '0;
         conts_left = '0;
         dropping   = 1'b0;
         expected_points.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata, req_tlast, produced, res);
            if (produced)
               expected_points = {expected_points, res};
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_points.size() == 0) begin
               note_failure($sformatf("unexpected item tdata %h tuser %0d tlast %b",
                                      rsp_tdata, rsp_tuser, rsp_tlast));
            end else begin
               want = expected_points.pop_front();
               if (rsp_tdata !== {3'b000, want.cp} || rsp_tuser !== want.status ||
                   rsp_tlast !== want.eos)
                  note_failure($sformatf(
                     "want cp %h status %0d eos %b, got tdata %h tuser %0d tlast %b",
                     want.cp, want.status, want.eos, rsp_tdata, rsp_tuser, rsp_tlast));
            end
         end
      end
      outstanding <= expected_points.size();
   end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the UTF-8 decoder: clock, reset, byte stimulus and final verdict.
`timescale 1ns / 1ps

module tb;

   localparam int DIRECTED_COUNT = 24;
   localparam int RANDOM_ITEMS   = 750;
   localparam int IDLE_PCT       = 17;
   localparam int STALL_LIMIT    = 2000;
   localparam int DRAIN_CYCLES   = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic        req_tlast = 1'b0;    // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // [20:0] code_point, [23:21] zero
   logic [2:0]  rsp_tuser;           // [2:0] status
   logic        rsp_tlast;           // end_of_string

   int   fail_count;
   int   outstanding;
   int   sent = 0;
   int   stall_cycles = 0;
   logic calm = 1'b0;

   // {last, byte}: ascii, 2/3/4-byte points incl. the largest, zero-valued
   // sequence, dropping after a stop, bad lead, bad continuation on the last
   // byte, truncation, stops on the last byte
   logic [8:0] directed_items[DIRECTED_COUNT] = '{
      9'h041, 9'h07F, 9'h0C3, 9'h0A9, 9'h0E2, 9'h082, 9'h0AC,
      9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF,
      9'h0C0, 9'h080, 9'h055, 9'h101,
      9'h0FF, 9'h120,
      9'h0E2, 9'h141,
      9'h0F0, 9'h19F,
      9'h180, 9'h100, 9'h1C2
   };

   always #5 clock = ~clock;

   utf8_to_codepoint_decoder_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   utf8_decode_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Receiver back-pressure
   always @(posedge clock)
      rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

   // Watchdog on cycles with no item moving
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Drive one byte, with random gaps, and wait until it is taken
   task automatic send_byte(input logic [7:0] b, input logic is_last);
      calm <= (sent >= 250 && sent < 420);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= is_last;
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   // Hold off the sender until every predicted result has come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Stimulus and verdict
   initial begin
      logic [7:0] str_bytes[$];
      logic [7:0] b;
      int         n_points;
      int         n_bytes;
      int         cut_at;
      int         pick;
      bit         pressure_done;
      pressure_done = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_items[i])
         send_byte(directed_items[i][7:0], directed_items[i][8]);
      wait_drained();

      while (sent < DIRECTED_COUNT + RANDOM_ITEMS) begin
         if (!pressure_done && sent >= 500) begin
            wait_drained();
            pressure_done = 1'b1;
         end
         if ($urandom_range(99) < 85) begin
            // well-formed string with random content and some damage
            str_bytes.delete();
            n_points = $urandom_range(1, 10);
            for (int p = 0; p < n_points; p++) begin
               n_bytes = $urandom_range(1, 4);
               case (n_bytes)
                  1: str_bytes = {str_bytes, 8'($urandom_range(1, 127))};
                  2: str_bytes = {str_bytes, 8'hC0 | 8'($urandom_range(31))};
                  3: str_bytes = {str_bytes, 8'hE0 | 8'($urandom_range(15))};
                  default: str_bytes = {str_bytes, 8'hF0 | 8'($urandom_range(7))};
               endcase
               for (int c = 1; c < n_bytes; c++)
                  str_bytes = {str_bytes, 8'h80 | 8'($urandom_range(63))};
            end
            foreach (str_bytes[i]) begin
               pick = $urandom_range(99);
               if (pick < 4)
                  str_bytes[i] = 8'($urandom_range(255));
               else if (pick == 4)
                  str_bytes[i] = 8'h00;
            end
            cut_at = str_bytes.size() - 1;
            if ($urandom_range(99) < 8)
               cut_at = $urandom_range(str_bytes.size() - 1);
            for (int i = 0; i <= cut_at; i++)
               send_byte(str_bytes[i], i == cut_at);
         end else begin
            // raw noise
            n_bytes = $urandom_range(1, 8);
            for (int i = 0; i < n_bytes; i++) begin
               b = 8'($urandom_range(255));
               send_byte(b, $urandom_range(3) == 0);
            end
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/utf8dec_pkg.sv
rtl/utf8dec_front.sv
rtl/utf8dec_queue.sv
rtl/utf8dec_back.sv
rtl/utf8_to_codepoint_decoder_unit.sv
rtl/utf8dec_checker.sv
tb/utf8_decode_checker.sv
tb/tb.sv
